// ----- rtl/core/bocs_pkg.sv -----
package bocs_pkg;

  // Field widths.
  localparam int unsigned VoltW = 13;
  localparam int unsigned CurW  = 14;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned CfgW  = 14;

  // Register indexes on the configuration port.
  localparam logic [IdxW-1:0] RegVbatLimit   = 3'd0;
  localparam logic [IdxW-1:0] RegVbatClear   = 3'd1;
  localparam logic [IdxW-1:0] RegIbatRated   = 3'd2;
  localparam logic [IdxW-1:0] RegCvIbatRated = 3'd3;
  localparam logic [IdxW-1:0] RegStep        = 3'd4;

  // Register reset values.
  localparam logic [VoltW-1:0] VbatLimitRst   = 13'd4400;
  localparam logic [VoltW-1:0] VbatClearRst   = 13'd4300;
  localparam logic [CurW-1:0]  IbatRatedRst   = 14'd1000;
  localparam logic [CurW-1:0]  CvIbatRatedRst = 14'd500;
  localparam logic [CurW-1:0]  StepRst        = 14'd100;

  // Action codes reported with each result item.
  typedef enum logic [1:0] {
    ACT_HOLD     = 2'd0,
    ACT_REDUCED  = 2'd1,
    ACT_RELEASED = 2'd2,
    ACT_IDLE     = 2'd3
  } action_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

endpackage

// ----- rtl/core/bocs_div.sv -----
// Restoring divider: one quotient bit per cycle through a single subtractor.
module bocs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bocs_pkg::CurW-1:0]   dividend_i,
  input  logic [bocs_pkg::CurW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [bocs_pkg::CurW-1:0]   quot_o,
  output logic [bocs_pkg::CurW-1:0]   rem_o
);

  localparam int unsigned W = bocs_pkg::CurW;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] LastCnt = CntW'(W - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W:0]      shifted;
  logic [W+1:0]    diff;

  // Shift in the next dividend bit and try one subtraction.
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // A clear borrow bit means the trial subtraction fits.
      if (!diff[W+1]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/core/battery_overvoltage_current_stepdown.sv -----
// Battery over-voltage current step-down. Each accepted item is one poll sample and yields
// exactly one result item with the current-limit vote and the action taken. An item that
// leads to a step-down with a nonzero step goes through the bit-serial divider, which finds
// the cap's remainder modulo the step, before it reaches the result register. The block
// takes a new item once the previous one has reached the result register, even while that
// result is still stalled. The user must write the configuration through the plain write
// port only while the block is idle; the block itself does not enforce this.
module battery_overvoltage_current_stepdown (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [bocs_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [bocs_pkg::CfgW-1:0]     cfg_wdata_i,
  // Sample channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          charging_i,
  input  logic                          sample_valid_i,
  input  logic [bocs_pkg::VoltW-1:0]    vbat_mv_i,
  input  logic [bocs_pkg::CurW-1:0]     icap_ma_i,
  input  logic                          taper_phase_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          vote_active_o,
  output logic [bocs_pkg::CurW-1:0]     vote_ma_o,
  output logic [1:0]                    action_o
);

  localparam int unsigned VW = bocs_pkg::VoltW;
  localparam int unsigned CW = bocs_pkg::CurW;

  // Configuration registers.
  logic [VW-1:0] vbat_limit_q, vbat_clear_q;
  logic [CW-1:0] ibat_rated_q, cv_ibat_rated_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbat_limit_q    <= bocs_pkg::VbatLimitRst;
      vbat_clear_q    <= bocs_pkg::VbatClearRst;
      ibat_rated_q    <= bocs_pkg::IbatRatedRst;
      cv_ibat_rated_q <= bocs_pkg::CvIbatRatedRst;
      step_q          <= bocs_pkg::StepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bocs_pkg::RegVbatLimit:   vbat_limit_q    <= cfg_wdata_i[VW-1:0];
        bocs_pkg::RegVbatClear:   vbat_clear_q    <= cfg_wdata_i[VW-1:0];
        bocs_pkg::RegIbatRated:   ibat_rated_q    <= cfg_wdata_i[CW-1:0];
        bocs_pkg::RegCvIbatRated: cv_ibat_rated_q <= cfg_wdata_i[CW-1:0];
        bocs_pkg::RegStep:        step_q          <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  bocs_pkg::state_e state_q, state_d;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Captured sample.
  logic          charging_q, sample_valid_q, taper_q;
  logic [VW-1:0] vbat_q;
  logic [CW-1:0] icap_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      charging_q     <= charging_i;
      sample_valid_q <= sample_valid_i;
      vbat_q         <= vbat_mv_i;
      icap_q         <= icap_ma_i;
      taper_q        <= taper_phase_i;
    end
  end

  // Decision on the captured sample.
  logic          below_limit, at_clear, above_rated, want_div;
  logic [CW-1:0] rated_thr;

  assign rated_thr   = taper_q ? cv_ibat_rated_q : ibat_rated_q;
  assign below_limit = vbat_q <= vbat_limit_q;
  assign at_clear    = vbat_q <= vbat_clear_q;
  assign above_rated = icap_q > rated_thr;
  assign want_div    = charging_q && sample_valid_q && !below_limit && above_rated &&
                       (step_q != '0);

  // Single divider for the remainder of the cap modulo the step.
  logic          div_start, div_done;
  logic [CW-1:0] div_quot, div_rem;

  bocs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (icap_q),
    .divisor_i  (step_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  logic out_free, out_load;
  assign out_free = !out_valid_o || !out_stall_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bocs_pkg::ST_IDLE: if (in_acc) state_d = bocs_pkg::ST_EVAL;
      bocs_pkg::ST_EVAL: state_d = want_div ? bocs_pkg::ST_DIV : bocs_pkg::ST_FIN;
      bocs_pkg::ST_DIV:  if (div_done) state_d = bocs_pkg::ST_FIN;
      bocs_pkg::ST_FIN:  if (out_free) state_d = bocs_pkg::ST_IDLE;
      default:           state_d = bocs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      bocs_pkg::ST_IDLE: in_stall_o = 1'b0;
      bocs_pkg::ST_EVAL: div_start  = want_div;
      bocs_pkg::ST_DIV:  ;
      bocs_pkg::ST_FIN:  out_load   = out_free;
      default:           ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bocs_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Vote state and the action of the item in flight.
  logic               limit_en_q, limit_en_d;
  logic [CW-1:0]      limit_val_q, limit_val_d;
  bocs_pkg::action_e  act_q, act_d;
  logic [CW-1:0]      stepped;

  // A nonzero quotient guarantees the cap minus remainder covers one step.
  assign stepped = icap_q - div_rem - step_q;

  always_comb begin
    limit_en_d  = limit_en_q;
    limit_val_d = limit_val_q;
    act_d       = act_q;
    if (state_q == bocs_pkg::ST_EVAL) begin
      if (!charging_q) begin
        limit_en_d  = 1'b0;
        limit_val_d = '0;
        act_d       = bocs_pkg::ACT_IDLE;
      end else if (!sample_valid_q) begin
        act_d = bocs_pkg::ACT_IDLE;
      end else if (below_limit) begin
        if (limit_en_q && at_clear) begin
          limit_en_d  = 1'b0;
          limit_val_d = '0;
          act_d       = bocs_pkg::ACT_RELEASED;
        end else begin
          act_d = bocs_pkg::ACT_HOLD;
        end
      end else if (!above_rated) begin
        act_d = bocs_pkg::ACT_HOLD;
      end else begin
        // A zero step keeps the cap as it is; otherwise the divider finishes it.
        limit_en_d = 1'b1;
        act_d      = bocs_pkg::ACT_REDUCED;
        if (step_q == '0) limit_val_d = icap_q;
      end
    end else if (state_q == bocs_pkg::ST_DIV && div_done) begin
      limit_val_d = (div_quot == '0) ? '0 : stepped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_en_q  <= 1'b0;
      limit_val_q <= '0;
      act_q       <= bocs_pkg::ACT_IDLE;
    end else begin
      limit_en_q  <= limit_en_d;
      limit_val_q <= limit_val_d;
      act_q       <= act_d;
    end
  end

  // Result register.
  logic          out_valid_q;
  logic          vote_active_q;
  logic [CW-1:0] vote_ma_q;
  logic [1:0]    action_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      vote_active_q <= limit_en_q;
      vote_ma_q     <= limit_en_q ? limit_val_q : '0;
      action_q      <= act_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vote_active_o = vote_active_q;
  assign vote_ma_o     = vote_ma_q;
  assign action_o      = action_q;

endmodule

// ----- rtl/core/bocs_checker.sv -----
// Port-level checks for the step-down block.
module bocs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          vote_active_o,
  input logic [bocs_pkg::CurW-1:0]     vote_ma_o,
  input logic [1:0]                    action_o
);

  // An accepted item keeps the sample channel closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sample channel open right after an accepted item");

  // No vote means a zero limit value.
  a_zero_when_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !vote_active_o |-> vote_ma_o == '0)
    else $error("nonzero vote value without an active vote");

  // A reduction always leaves a vote in force.
  a_reduced_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == bocs_pkg::ACT_REDUCED |-> vote_active_o)
    else $error("reduced action without an active vote");

  // A release always removes the vote.
  a_released_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == bocs_pkg::ACT_RELEASED |-> !vote_active_o)
    else $error("released action with an active vote");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result item dropped");

endmodule

bind battery_overvoltage_current_stepdown bocs_checker u_bocs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .vote_active_o (vote_active_o),
  .vote_ma_o     (vote_ma_o),
  .action_o      (action_o)
);

// ----- verif/tb_battery_overvoltage_current_stepdown.sv -----
module tb_battery_overvoltage_current_stepdown;
  import bocs_pkg::*;

  localparam int VMax = (1 << VoltW) - 1;
  localparam int CMax = (1 << CurW) - 1;
  localparam int DrainCycles = 20;
  localparam int CycleLimit = 400000;

  // One poll sample and the vote that it leaves behind.
  typedef struct packed {
    logic             charging;
    logic             sample_ok;
    logic [VoltW-1:0] vbat;
    logic [CurW-1:0]  icap;
    logic             taper;
  } sample_t;

  typedef struct packed {
    logic            active;
    logic [CurW-1:0] cap;
    action_e         act;
  } vote_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]  cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             charging_i = 1'b0;
  logic             sample_valid_i = 1'b0;
  logic [VoltW-1:0] vbat_mv_i = '0;
  logic [CurW-1:0]  icap_ma_i = '0;
  logic             taper_phase_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             vote_active_o;
  logic [CurW-1:0]  vote_ma_o;
  logic [1:0]       action_o;

  // Register copies and vote state of the predictor.
  logic [VoltW-1:0] lim_mv = VbatLimitRst;
  logic [VoltW-1:0] clr_mv = VbatClearRst;
  logic [CurW-1:0]  rated_ma = IbatRatedRst;
  logic [CurW-1:0]  cv_rated_ma = CvIbatRatedRst;
  logic [CurW-1:0]  step_ma = StepRst;
  logic             vote_on = 1'b0;
  logic [CurW-1:0]  vote_cap = '0;

  sample_t sample_q[$];
  vote_t   vote_q[$];
  sample_t drv_sample;
  vote_t   exp_vote;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      send_quiet = 0;
  int      recv_quiet = 0;
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;

  battery_overvoltage_current_stepdown u_top (.*);

  always #5 clk_i = ~clk_i;

  // Applies one sample to the predicted vote and returns the expected result item.
  function automatic vote_t step_vote(sample_t s);
    vote_t       v;
    action_e     act;
    int unsigned k;
    if (!s.charging) begin
      vote_on = 1'b0;
      vote_cap = '0;
      act = ACT_IDLE;
    end else if (!s.sample_ok) begin
      act = ACT_IDLE;
    end else if (s.vbat <= lim_mv) begin
      if (vote_on && s.vbat <= clr_mv) begin
        vote_on = 1'b0;
        vote_cap = '0;
        act = ACT_RELEASED;
      end else begin
        act = ACT_HOLD;
      end
    end else if (s.icap <= (s.taper ? cv_rated_ma : rated_ma)) begin
      act = ACT_HOLD;
    end else begin
      // Round down to a step multiple and take one step off; a zero step keeps the cap.
      if (step_ma == '0) begin
        vote_cap = s.icap;
      end else begin
        k = s.icap / step_ma;
        vote_cap = (k == 0) ? '0 : CurW'((k - 1) * step_ma);
      end
      vote_on = 1'b1;
      act = ACT_REDUCED;
    end
    v.active = vote_on;
    v.cap = vote_on ? vote_cap : '0;
    v.act = act;
    return v;
  endfunction

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Random sample, biased toward the thresholds and step multiples of the current setting.
  function automatic sample_t draw_sample();
    sample_t s;
    int      v;
    int      c;
    int      thr;
    int      stp;
    s.charging = ($urandom_range(99) < 94);
    s.sample_ok = ($urandom_range(99) < 93);
    s.taper = 1'($urandom_range(1));
    thr = s.taper ? int'(cv_rated_ma) : int'(rated_ma);
    stp = (step_ma == '0) ? 1 : int'(step_ma);
    case ($urandom_range(9))
      0, 1, 2: v = int'(lim_mv) + int'($urandom_range(6)) - 3;
      3, 4:    v = int'(clr_mv) + int'($urandom_range(6)) - 3;
      5:       v = $urandom_range(1) ? VMax : 0;
      6:       v = int'($urandom_range(VMax, lim_mv));
      7:       v = int'($urandom_range(clr_mv));
      default: v = int'($urandom_range(VMax));
    endcase
    case ($urandom_range(7))
      0, 1:    c = thr + int'($urandom_range(4)) - 2;
      2:       c = stp * int'($urandom_range(CMax / stp)) + int'($urandom_range(2)) - 1;
      3:       c = $urandom_range(1) ? CMax : 0;
      4:       c = int'($urandom_range(step_ma));
      default: c = int'($urandom_range(CMax));
    endcase
    s.vbat = VoltW'(clip(v, VMax));
    s.icap = CurW'(clip(c, CMax));
    return s;
  endfunction

  function automatic void add_sample(logic ch, logic ok, int vbat, int icap, logic taper);
    sample_t s;
    s.charging = ch;
    s.sample_ok = ok;
    s.vbat = VoltW'(vbat);
    s.icap = CurW'(icap);
    s.taper = taper;
    sample_q.push_back(s);
  endfunction

  // Drives one register write and mirrors it into the predictor; the caller lowers the enable.
  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegVbatLimit:   lim_mv = data[VoltW-1:0];
      RegVbatClear:   clr_mv = data[VoltW-1:0];
      RegIbatRated:   rated_ma = data[CurW-1:0];
      RegCvIbatRated: cv_rated_ma = data[CurW-1:0];
      RegStep:        step_ma = data[CurW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [VoltW-1:0] lim, logic [VoltW-1:0] clr,
                              logic [CurW-1:0] rated, logic [CurW-1:0] cv_rated,
                              logic [CurW-1:0] stp);
    // The spare top bit of a voltage write is random and must be dropped by the block.
    write_reg(RegVbatLimit, {1'($urandom), lim});
    write_reg(RegVbatClear, {1'($urandom), clr});
    write_reg(RegIbatRated, rated);
    write_reg(RegCvIbatRated, cv_rated);
    write_reg(RegStep, stp);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || vote_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_random(int n);
    @(negedge clk_i);
    repeat (n) sample_q.push_back(draw_sample());
    wait_drained();
  endtask

  // Sample driver: predicts each accepted item and loads the next one when the bus is free.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      vote_q.push_back(step_vote(drv_sample));
    end
    if (send_quiet != 0) begin
      send_quiet--;
    end else if ($urandom_range(59) == 0) begin
      send_quiet = $urandom_range(40, 10);
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (rst_ni && sample_q.size() != 0 &&
          (send_quiet != 0 || $urandom_range(99) >= send_idle_pct)) begin
        drv_sample = sample_q.pop_front();
        in_valid_i <= 1'b1;
        charging_i <= drv_sample.charging;
        sample_valid_i <= drv_sample.sample_ok;
        vbat_mv_i <= drv_sample.vbat;
        icap_ma_i <= drv_sample.icap;
        taper_phase_i <= drv_sample.taper;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor: checks each accepted item against the oldest expected vote.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (vote_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result: active=%0b ma=%0d action=%0d",
                   vote_active_o, vote_ma_o, action_o);
        end
      end else begin
        exp_vote = vote_q.pop_front();
        if (exp_vote.active !== vote_active_o || exp_vote.cap !== vote_ma_o ||
            exp_vote.act !== action_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("vote mismatch: expected active=%0b ma=%0d action=%0d, got %0b %0d %0d",
                     exp_vote.active, exp_vote.cap, exp_vote.act,
                     vote_active_o, vote_ma_o, action_o);
          end
        end
      end
    end
    if (recv_quiet != 0) begin
      recv_quiet--;
    end else if ($urandom_range(59) == 0) begin
      recv_quiet = $urandom_range(40, 10);
    end
    out_stall_i <= (recv_quiet == 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** battery_overvoltage_current_stepdown: FAILED **");
      $finish;
    end
  end

  // Stimulus sequence: directed samples, then random phases over several settings.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    send_idle_pct = 24;
    recv_idle_pct = 87;

    // Reset settings: release, idle on invalid, limit edges, rated edges, repeated reduction.
    add_sample(1'b0, 1'b1, VMax, CMax, 1'b1);
    add_sample(1'b1, 1'b0, VMax, CMax, 1'b0);
    add_sample(1'b1, 1'b1, 4400, CMax, 1'b0);
    add_sample(1'b1, 1'b1, 4401, 1000, 1'b0);
    add_sample(1'b1, 1'b1, 4401, 1001, 1'b0);
    add_sample(1'b1, 1'b1, VMax, CMax, 1'b1);
    add_sample(1'b1, 1'b1, 5000, 550, 1'b1);
    add_sample(1'b1, 1'b1, 4350, 0, 1'b0);
    add_sample(1'b1, 1'b0, 0, 0, 1'b0);
    add_sample(1'b1, 1'b1, 4300, 0, 1'b0);
    add_sample(1'b1, 1'b1, 4300, 0, 1'b0);
    add_sample(1'b1, 1'b1, VMax, 501, 1'b1);
    add_sample(1'b0, 1'b0, 0, 0, 1'b0);
    add_sample(1'b1, 1'b1, 0, 0, 1'b0);
    add_sample(1'b1, 1'b1, VMax, 99, 1'b1);
    add_sample(1'b1, 1'b1, 4401, CMax, 1'b0);
    add_sample(1'b1, 1'b1, 0, CMax, 1'b0);
    wait_drained();

    // Zero step keeps the cap; a clear level above the limit only releases at the limit.
    apply_config(13'd100, 13'd200, 14'd0, 14'd0, 14'd0);
    @(negedge clk_i);
    add_sample(1'b1, 1'b1, VMax, 12345, 1'b0);
    add_sample(1'b1, 1'b1, 150, 0, 1'b1);
    add_sample(1'b1, 1'b1, 100, 0, 1'b0);
    wait_drained();

    // A cap below one step floors the vote at zero.
    write_reg(RegStep, CurW'(CMax));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    add_sample(1'b1, 1'b1, VMax, CMax - 1, 1'b0);
    add_sample(1'b1, 1'b1, VMax, CMax, 1'b1);
    add_sample(1'b0, 1'b1, VMax, CMax, 1'b0);
    wait_drained();

    apply_config(13'd4200, 13'd4000, 14'd1500, 14'd700, 14'd50);
    run_random(280);
    apply_config(VoltW'($urandom), VoltW'($urandom), CurW'($urandom), CurW'($urandom),
                 CurW'($urandom_range(CMax, 1)));
    run_random(280);

    @(negedge clk_i);
    send_idle_pct = 87;
    recv_idle_pct = 24;
    apply_config(13'd0, 13'd0, 14'd0, 14'd0, 14'd1);
    run_random(280);
    apply_config(VoltW'(VMax - 1), VoltW'(VMax), CurW'(CMax), 14'd0, CurW'(CMax));
    run_random(200);

    // Writes to the unused indexes must leave every register alone.
    apply_config(VoltW'($urandom), VoltW'($urandom), CurW'($urandom), CurW'($urandom), 14'd0);
    for (int i = int'(RegStep) + 1; i < (1 << IdxW); i++) begin
      write_reg(IdxW'(i), CfgW'($urandom));
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    run_random(280);

    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(VoltW'($urandom_range(4000, 3000)), VoltW'($urandom_range(3000, 2800)),
                 CurW'($urandom_range(3000)), CurW'($urandom_range(3000)),
                 CurW'($urandom_range(300, 1)));
    run_random(280);

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && vote_q.size() == 0) begin
      $display("** battery_overvoltage_current_stepdown: PASSED **");
    end else begin
      $display("** battery_overvoltage_current_stepdown: FAILED **");
    end
    $finish;
  end

endmodule

// ----- battery_overvoltage_current_stepdown.f -----
rtl/core/bocs_pkg.sv
rtl/core/bocs_div.sv
rtl/core/battery_overvoltage_current_stepdown.sv
rtl/core/bocs_checker.sv
verif/tb_battery_overvoltage_current_stepdown.sv
